FILE: rtl/cfv_pkg.sv
// ----------------------------------------------------------------------------
// cfv_pkg: shared types, constants and functions for the clip file validator
// Header layout, verdict codes, register indexes, CRC-16 byte step and the
// call sign character filter.
// ----------------------------------------------------------------------------
package cfv_pkg;

  localparam int HEADER_BYTES    = 32;
  localparam int CALL_SIGN_BYTES = 5;
  localparam int CALL_SIGN_OFF   = 20;
  localparam int QUEUE_DEPTH     = 2;
  localparam int OUT_BITS        = 152;

  // CRC-16/CCITT-FALSE
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [7:0] CHAR_UNKNOWN = 8'h3F;  // '?'
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;

  // verdict codes
  localparam logic [3:0] V_VALID   = 4'd0;
  localparam logic [3:0] V_SHORT   = 4'd1;
  localparam logic [3:0] V_MAGIC   = 4'd2;
  localparam logic [3:0] V_VERSION = 4'd3;
  localparam logic [3:0] V_HDR_CRC = 4'd4;
  localparam logic [3:0] V_LENGTH  = 4'd5;
  localparam logic [3:0] V_CHANNEL = 4'd6;
  localparam logic [3:0] V_SIZE    = 4'd7;
  localparam logic [3:0] V_PAY_CRC = 4'd8;

  // configuration register indexes
  localparam logic [2:0] REG_MAGIC    = 3'd0;
  localparam logic [2:0] REG_VERSION  = 3'd1;
  localparam logic [2:0] REG_MAX_PAY  = 3'd2;
  localparam logic [2:0] REG_CHANNELS = 3'd3;
  localparam logic [2:0] REG_VERIFY   = 3'd4;

  typedef logic [HEADER_BYTES-1:0][7:0] header_t;

  // one finished file as handed from the front to the back
  typedef struct packed {
    logic    short_file;
    logic    hcrc_ok;
    logic    pcrc_ok;
    logic    size_ok;
    header_t hdr;
  } record_t;

  typedef struct packed {
    logic [31:0] expected_magic;
    logic [7:0]  format_version;
    logic [15:0] max_payload;
    logic [8:0]  channel_count;
    logic        verify_payload;
  } cfg_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] sanitize(input logic [7:0] c);
    logic ok;
    ok = (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
         (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) || (c == CHAR_SPACE);
    return ok ? c : CHAR_UNKNOWN;
  endfunction

endpackage

FILE: rtl/cfv_front.sv
// ----------------------------------------------------------------------------
// cfv_front: byte intake
// Counts bytes, keeps the header, runs the header and payload CRCs and on the
// final byte pushes a record with the CRC and size compares already done.
// ----------------------------------------------------------------------------
module cfv_front #(
  parameter int COUNT_BITS = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  output logic             push,
  output cfv_pkg::record_t rec
);
  import cfv_pkg::*;

  localparam int IDX_BITS = $clog2(HEADER_BYTES);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] HDR_LEN   = COUNT_BITS'(HEADER_BYTES);
  localparam logic [COUNT_BITS-1:0] HCRC_END  = COUNT_BITS'(HEADER_BYTES - 2);

  logic [COUNT_BITS-1:0] byte_count, byte_count_next;
  logic [15:0]           header_crc, header_crc_next;
  logic [15:0]           payload_crc, payload_crc_next;
  header_t               hdr, hdr_next;
  logic                  hdr_en, hcrc_en, pcrc_en;
  logic [15:0]           crc_upd;

  always_comb begin
    hdr_en  = byte_count < HDR_LEN;
    hcrc_en = byte_count < HCRC_END;
    pcrc_en = !hdr_en && (byte_count != COUNT_MAX);
    // one CRC step shared by both sums; they never run in the same byte
    crc_upd = crc_byte(hdr_en ? header_crc : payload_crc, data_byte);
    header_crc_next  = hcrc_en ? crc_upd : header_crc;
    payload_crc_next = pcrc_en ? crc_upd : payload_crc;
    byte_count_next  = (byte_count == COUNT_MAX) ? byte_count : byte_count + 1'b1;
    for (int i = 0; i < HEADER_BYTES; i++) begin
      hdr_next[i] = (hdr_en && byte_count[IDX_BITS-1:0] == IDX_BITS'(i)) ? data_byte : hdr[i];
    end
  end

  assign push           = accept && last_byte;
  assign rec.short_file = byte_count_next < HDR_LEN;
  assign rec.hdr        = hdr_next;
  assign rec.hcrc_ok    = {hdr_next[31], hdr_next[30]} == header_crc_next;
  assign rec.pcrc_ok    = {hdr_next[19], hdr_next[18]} == payload_crc_next;
  assign rec.size_ok    = byte_count_next == HDR_LEN + COUNT_BITS'({hdr_next[17], hdr_next[16]});

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      header_crc  <= CRC_INIT;
      payload_crc <= CRC_INIT;
    end else if (accept) begin
      if (last_byte) begin
        byte_count  <= '0;
        header_crc  <= CRC_INIT;
        payload_crc <= CRC_INIT;
      end else begin
        byte_count  <= byte_count_next;
        header_crc  <= header_crc_next;
        payload_crc <= payload_crc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hdr <= hdr_next;
    end
  end

endmodule

FILE: rtl/cfv_queue.sv
// ----------------------------------------------------------------------------
// cfv_queue: record queue
// Short FIFO of finished file records between intake and verdict logic.
// ----------------------------------------------------------------------------
module cfv_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cfv_pkg::record_t rec_in,
  input  logic             pop,
  output logic             full,
  output logic             q_valid,
  output cfv_pkg::record_t rec_out
);
  import cfv_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);

  record_t             mem [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full    = count == CNT_BITS'(QUEUE_DEPTH);
  assign q_valid = count != '0;
  assign rec_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= rec_in;
    end
  end

endmodule

FILE: rtl/cfv_back.sv
// ----------------------------------------------------------------------------
// cfv_back: verdict and result register
// Runs the ordered header checks, decodes the fields, cleans the call sign
// and holds the result until the downstream side takes it.
// ----------------------------------------------------------------------------
module cfv_back (
  input  logic                         clk,
  input  logic                         rst,
  input  cfv_pkg::cfg_t                cfg,
  input  logic                         q_valid,
  input  cfv_pkg::record_t             rec,
  output logic                         pop,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [cfv_pkg::OUT_BITS-1:0] m_tdata
);
  import cfv_pkg::*;

  logic [3:0]                      verdict;
  logic [15:0]                     plen;
  logic [CALL_SIGN_BYTES-1:0][7:0] san, call;
  logic [2:0]                      call_len;
  logic [OUT_BITS-1:0]             result;

  always_comb begin
    plen = {rec.hdr[17], rec.hdr[16]};
    priority if ({rec.hdr[3], rec.hdr[2], rec.hdr[1], rec.hdr[0]} != cfg.expected_magic)
      verdict = V_MAGIC;
    else if (rec.hdr[4] != cfg.format_version)
      verdict = V_VERSION;
    else if (!rec.hcrc_ok)
      verdict = V_HDR_CRC;
    else if (plen == '0 || plen > cfg.max_payload)
      verdict = V_LENGTH;
    else if (!rec.size_ok)
      verdict = V_SIZE;
    else if ({1'b0, rec.hdr[5]} >= cfg.channel_count)
      verdict = V_CHANNEL;
    else if (cfg.verify_payload && !rec.pcrc_ok)
      verdict = V_PAY_CRC;
    else
      verdict = V_VALID;

    call_len = '0;
    for (int i = 0; i < CALL_SIGN_BYTES; i++) begin
      san[i] = sanitize(rec.hdr[CALL_SIGN_OFF + i]);
      if (san[i] != CHAR_SPACE) begin
        call_len = 3'(i + 1);
      end
    end
    // slots past the trimmed length read as zero
    for (int i = 0; i < CALL_SIGN_BYTES; i++) begin
      call[i] = (3'(i) < call_len) ? san[i] : 8'h00;
    end

    if (rec.short_file) begin
      result = {{(OUT_BITS - 4){1'b0}}, V_SHORT};
    end else begin
      result = {1'b0, call_len, call, plen,
                rec.hdr[15], rec.hdr[14], rec.hdr[13], rec.hdr[12],
                rec.hdr[11], rec.hdr[10], rec.hdr[9], rec.hdr[8],
                rec.hdr[7], rec.hdr[6], rec.hdr[5], verdict};
    end
  end

  assign pop = q_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= result;
    end
  end

endmodule

FILE: rtl/clip_file_validator_core.sv
// ----------------------------------------------------------------------------
// clip_file_validator_core: framed clip file check with CRC-16/CCITT-FALSE
//
//   channel  dir  signals                              carries
//   s_*      in   tvalid tready tdata[7:0] tlast       file byte, final-byte mark
//   m_*      out  tvalid tready tdata[151:0]           one verdict per file
//   cfg_*    in   valid ready index[2:0] data[31:0]    register write
//
// One byte per cycle while s_tready is high; the intake CRC step is a single
// unrolled 8-bit update. After the final byte's transaction the record enters
// the queue; m_tvalid is set when it is popped into the free result register.
// Synchronous reset clears byte count, queue and result valid, presets CRCs.
// A two-record queue sits between intake and verdict; s_tready drops only
// when it is full, and the result register holds while m_tready is low.
// ----------------------------------------------------------------------------
module clip_file_validator_core #(
  parameter int COUNT_BITS = 17
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // [7:0] data_byte
  input  logic                         s_tlast,   // last_byte
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [3:0] verdict, [11:4] channel, [27:12] length_10ms, [59:28] receive_time,
  // [91:60] sequence_res, [107:92] payload_length, [147:108] call_sign,
  // [150:148] call_sign_length, [151] zero
  output logic [cfv_pkg::OUT_BITS-1:0] m_tdata,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [31:0]                  cfg_data
);
  import cfv_pkg::*;

  cfg_t    cfg;
  logic    accept, push, full, q_valid, pop;
  record_t rec_in, rec_out;

  assign cfg_ready = 1'b1;
  assign s_tready  = !full;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_magic <= 32'h0;
      cfg.format_version <= 8'd1;
      cfg.max_payload    <= 16'd1536;
      cfg.channel_count  <= 9'd8;
      cfg.verify_payload <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAGIC:    cfg.expected_magic <= cfg_data;
        REG_VERSION:  cfg.format_version <= cfg_data[7:0];
        REG_MAX_PAY:  cfg.max_payload    <= cfg_data[15:0];
        REG_CHANNELS: cfg.channel_count  <= cfg_data[8:0];
        REG_VERIFY:   cfg.verify_payload <= cfg_data[0];
        default: ;
      endcase
    end
  end

  cfv_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (s_tdata),
    .last_byte (s_tlast),
    .push      (push),
    .rec       (rec_in)
  );

  cfv_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .rec_in  (rec_in),
    .pop     (pop),
    .full    (full),
    .q_valid (q_valid),
    .rec_out (rec_out)
  );

  cfv_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .rec      (rec_out),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // short file carries nothing but its verdict
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3:0] == V_SHORT |-> m_tdata[OUT_BITS-1:4] == '0)
    else $error("short verdict with nonzero fields");

  // a passing file always names a channel below the count
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3:0] == V_VALID |-> {1'b0, m_tdata[11:4]} < cfg.channel_count)
    else $error("valid verdict with channel out of range");

  // trimmed call sign never longer than its field
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[150:148] <= 3'(CALL_SIGN_BYTES))
    else $error("call sign length out of range");

  // a final byte lands in the queue and leaves it on the next free output slot
  assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast && !m_tvalid && !q_valid |=> q_valid && pop)
    else $error("record not forwarded to idle output");

endmodule
